// File: hw/rtl/psd_pkg.sv
// Shared widths and handshake structs for the prime sum block.
package psd_pkg;

  localparam int COUNT_W   = 11;  // prime_count field
  localparam int SUM_W     = 24;  // prime_sum field
  localparam int CAND_W    = 16;  // holds the 4096th prime (38873)
  localparam int D_W       = 9;   // odd trial divisor, up to sqrt of the largest candidate
  localparam int SQ_W      = 17;  // square of the trial divisor, one step past the bound
  localparam int BIT_CNT_W = 5;   // counts the CAND_W dividend bits

  // Request to the serial remainder unit.
  typedef struct packed {
    logic              start;
    logic [CAND_W-1:0] dividend;
    logic [D_W-1:0]    divisor;
  } rem_req_t;

  // Status back from the serial remainder unit.
  typedef struct packed {
    logic busy;
    logic done;
    logic zero;
  } rem_rsp_t;

endpackage

// File: hw/rtl/psd_if.sv
// Valid/ready channel interfaces for the count input and the sum output.
interface psd_count_if;
  logic                         valid;
  logic                         ready;
  logic [psd_pkg::COUNT_W-1:0]  prime_count;

  modport source (output valid, output prime_count, input ready);
  modport sink   (input valid, input prime_count, output ready);
endinterface

interface psd_sum_if;
  logic                       valid;
  logic                       ready;
  logic [psd_pkg::SUM_W-1:0]  prime_sum;

  modport source (output valid, output prime_sum, input ready);
  modport sink   (input valid, input prime_sum, output ready);
endinterface

// File: hw/rtl/psd_rem.sv
// Bit-serial restoring remainder: one dividend bit per cycle.
module psd_rem (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  psd_pkg::rem_req_t req_i,
  output psd_pkg::rem_rsp_t rsp_o
);

  logic                           busy_q;
  logic                           done_q;
  logic [psd_pkg::BIT_CNT_W-1:0]  cnt_q;
  logic [psd_pkg::CAND_W-1:0]     shf_q;
  logic [psd_pkg::D_W-1:0]        dvs_q;
  logic [psd_pkg::D_W-1:0]        rem_q;
  logic [psd_pkg::D_W-1:0]        rem_d;
  logic [psd_pkg::D_W:0]          trial;
  logic [psd_pkg::D_W:0]          diff;

  // remainder stays below the divisor, so trial < 2*divisor and diff fits D_W
  always_comb begin
    trial = {rem_q, shf_q[psd_pkg::CAND_W-1]};
    diff  = trial - {1'b0, dvs_q};
    rem_d = (trial >= {1'b0, dvs_q}) ? diff[psd_pkg::D_W-1:0] : trial[psd_pkg::D_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + psd_pkg::BIT_CNT_W'(1);
        if (cnt_q == psd_pkg::BIT_CNT_W'(psd_pkg::CAND_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      shf_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      shf_q <= {shf_q[psd_pkg::CAND_W-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.zero = (rem_q == '0);

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> done_q)
    else $error("remainder done missing after busy ends");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("remainder done while still busy");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |=> busy_q && cnt_q == '0)
    else $error("remainder start did not launch");

endmodule

// File: hw/rtl/prime_sum_trial_division.sv
// Top level: sum of the first N primes found by bit-serial trial division.
//
// Usage:
//   cnt_i carries prime_count; a beat is taken when valid and ready are high.
//   sum_o carries prime_sum, one beat for each count beat, in order.
//   Counts above MAX_COUNT saturate; a count of 0 returns 0.
// Search:
//   Candidates are walked from 2. Each trial divisor costs one pass of the
//   bit-serial remainder unit over all CAND_W = 16 dividend bits, plus the
//   ST_LOOP bound check; even candidates are rejected in ST_TEST. Run time
//   grows with the number of divisor trials and with the last candidate, and
//   the remainder unit dominates it.
// Throughput:
//   One count at a time; cnt_i.ready is high only while idle. A new count
//   is taken while the previous sum still waits in the output register.
// Stall:
//   If sum_o is stalled when the next sum is ready, the block waits with it.
// Reset:
//   rst_ni (async, active low) clears the sequencer and the output valid.
module prime_sum_trial_division #(
  parameter int MAX_COUNT = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  psd_count_if.sink           cnt_i,
  psd_sum_if.source           sum_o
);

  localparam int CNT_W = $clog2(MAX_COUNT + 1);
  localparam int CMP_W = (CNT_W > psd_pkg::COUNT_W) ? CNT_W : psd_pkg::COUNT_W;

  // sequencer codes
  localparam logic [2:0] ST_IDLE = 3'd0;  // waiting for a count
  localparam logic [2:0] ST_TEST = 3'd1;  // done check, trivial cases
  localparam logic [2:0] ST_LOOP = 3'd2;  // bound check, launch a trial
  localparam logic [2:0] ST_DIV  = 3'd3;  // remainder in progress
  localparam logic [2:0] ST_DONE = 3'd4;  // hand sum to the output register

  logic [2:0]                  state_q, state_d;
  logic [CNT_W-1:0]            want_q, want_d;
  logic [CNT_W-1:0]            found_q, found_d;
  logic [psd_pkg::CAND_W-1:0]  cand_q, cand_d;
  logic [psd_pkg::D_W-1:0]     d_q, d_d;
  logic [psd_pkg::SQ_W-1:0]    sq_q, sq_d;
  logic [psd_pkg::SUM_W-1:0]   sum_q, sum_d;
  logic                        out_vld_q, out_vld_d;
  logic [psd_pkg::SUM_W-1:0]   out_sum_q, out_sum_d;

  logic [CMP_W-1:0]            cnt_ext;
  logic                        is_prime;
  logic                        not_prime;
  psd_pkg::rem_req_t           rem_req;
  psd_pkg::rem_rsp_t           rem_rsp;

  psd_rem u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rem_req),
    .rsp_o  (rem_rsp)
  );

  assign cnt_i.ready     = (state_q == ST_IDLE);
  assign sum_o.valid     = out_vld_q;
  assign sum_o.prime_sum = out_sum_q;
  assign cnt_ext         = CMP_W'(cnt_i.prime_count);

  always_comb begin
    state_d   = state_q;
    want_d    = want_q;
    found_d   = found_q;
    cand_d    = cand_q;
    d_d       = d_q;
    sq_d      = sq_q;
    sum_d     = sum_q;
    out_vld_d = out_vld_q;
    out_sum_d = out_sum_q;
    is_prime  = 1'b0;
    not_prime = 1'b0;

    rem_req.start    = 1'b0;
    rem_req.dividend = cand_q;
    rem_req.divisor  = d_q;

    if (out_vld_q && sum_o.ready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (cnt_i.valid) begin
          // saturate the count at MAX_COUNT
          want_d  = (cnt_ext > CMP_W'(MAX_COUNT)) ? CNT_W'(MAX_COUNT) : CNT_W'(cnt_ext);
          found_d = '0;
          cand_d  = psd_pkg::CAND_W'(2);
          sum_d   = '0;
          state_d = ST_TEST;
        end
      end
      ST_TEST: begin
        if (found_q == want_q) begin
          state_d = ST_DONE;
        end else if (cand_q == psd_pkg::CAND_W'(2)) begin
          is_prime = 1'b1;
        end else if (!cand_q[0]) begin
          not_prime = 1'b1;
        end else begin
          d_d     = psd_pkg::D_W'(3);
          sq_d    = psd_pkg::SQ_W'(9);
          state_d = ST_LOOP;
        end
      end
      ST_LOOP: begin
        if (sq_q > psd_pkg::SQ_W'(cand_q)) begin
          is_prime = 1'b1;
        end else begin
          rem_req.start = 1'b1;
          state_d       = ST_DIV;
        end
      end
      ST_DIV: begin
        if (rem_rsp.done) begin
          if (rem_rsp.zero) begin
            not_prime = 1'b1;
          end else begin
            // (d+2)^2 = d^2 + 4d + 4
            sq_d    = sq_q + psd_pkg::SQ_W'({d_q, 2'b00}) + psd_pkg::SQ_W'(4);
            d_d     = d_q + psd_pkg::D_W'(2);
            state_d = ST_LOOP;
          end
        end
      end
      ST_DONE: begin
        if (!out_vld_q || sum_o.ready) begin
          out_vld_d = 1'b1;
          out_sum_d = sum_q;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (is_prime) begin
      sum_d   = sum_q + psd_pkg::SUM_W'(cand_q);
      found_d = found_q + CNT_W'(1);
    end
    if (is_prime || not_prime) begin
      cand_d  = cand_q + psd_pkg::CAND_W'(1);
      state_d = ST_TEST;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
      found_q   <= '0;
      want_q    <= '0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      found_q   <= found_d;
      want_q    <= want_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q    <= cand_d;
    d_q       <= d_d;
    sq_q      <= sq_d;
    sum_q     <= sum_d;
    out_sum_q <= out_sum_d;
  end

  a_found_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (found_q <= want_q))
    else $error("found count passed the requested count");

  a_start_idle_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_req.start |-> (state_q == ST_LOOP) && !rem_rsp.busy)
    else $error("remainder launched out of turn");

  a_odd_trial: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> d_q[0] && cand_q[0])
    else $error("trial with even divisor or candidate");

  a_accept_test: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_i.valid && cnt_i.ready) |=> (state_q == ST_TEST) && (found_q == '0))
    else $error("count beat did not start a search");

  a_done_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && state_d == ST_IDLE) |=> out_vld_q)
    else $error("sum not presented after search");

endmodule
